// File: design/iva_pkg.sv
// Shared widths, mode codes and controller/datapath interface types for the aggregator.
package iva_pkg;

   localparam int COUNT_WIDTH   = 16;
   localparam int SUM_WIDTH     = 64;
   localparam int POS_WIDTH     = 31;
   localparam int VALUE_WIDTH   = 32;
   localparam int MODE_WIDTH    = 2;
   localparam int SEEN_WIDTH    = 2;
   localparam int PROD_WIDTH    = VALUE_WIDTH + COUNT_WIDTH + 1;
   localparam int ACC_WIDTH     = ((SUM_WIDTH > PROD_WIDTH) ? SUM_WIDTH : PROD_WIDTH) + 1;
   localparam int CMP_WIDTH     = (POS_WIDTH > COUNT_WIDTH) ? POS_WIDTH : COUNT_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH);

   localparam logic [MODE_WIDTH-1:0] MODE_MAX  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_MIN  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_AVG  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_NONE = 2'd3;

   localparam logic [SEEN_WIDTH-1:0] SEEN_ONE = 2'd1;
   localparam logic [SEEN_WIDTH-1:0] SEEN_SAT = 2'd2;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [SUM_WIDTH-1:0]   SUM_MAX   = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0]   SUM_MIN   = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic capture;
      logic span;
      logic clip;
      logic mul;
      logic acc;
      logic div_start;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic needs_div;
      logic div_done;
   } status_type;

endpackage

// File: design/iva_divider.sv
// Bit-serial signed divider: one quotient bit per step, truncation toward zero.
module iva_divider
   import iva_pkg::*;
(
   input  logic                          clock,
   input  logic                          start,
   input  logic                          step,
   input  logic signed [SUM_WIDTH-1:0]   dividend,
   input  logic        [COUNT_WIDTH-1:0] divisor,
   output logic signed [VALUE_WIDTH-1:0] quotient,
   output logic                          done
);

   logic                     neg_ff, neg_in;
   logic [SUM_WIDTH-1:0]     quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [COUNT_WIDTH:0]     trial;
   logic [COUNT_WIDTH:0]     diff;
   logic                     ge;
   logic [VALUE_WIDTH-1:0]   low;

   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_WIDTH-1]};
      diff   = trial - {1'b0, divisor};
      ge     = trial >= {1'b0, divisor};
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         neg_in = dividend[SUM_WIDTH-1];
         quo_in = dividend[SUM_WIDTH-1] ? -dividend : dividend;
         rem_in = '0;
         cnt_in = DIV_CNT_WIDTH'(SUM_WIDTH - 1);
      end else if (step) begin
         quo_in = {quo_ff[SUM_WIDTH-2:0], ge};
         rem_in = ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
         cnt_in = cnt_ff - DIV_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   // Low bits of the negated quotient depend only on the low bits of the magnitude.
   assign low      = quo_ff[VALUE_WIDTH-1:0];
   assign quotient = neg_ff ? $signed(-low) : $signed(low);
   assign done     = (cnt_ff == '0);

endmodule

// File: design/iva_datapath.sv
// Datapath: overlap weight, running max/min, weighted sum, count, divider and result register.
module iva_datapath
   import iva_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic        [POS_WIDTH-1:0]   req_interval_start,
   input  logic        [POS_WIDTH-1:0]   req_interval_end,
   input  logic signed [VALUE_WIDTH-1:0] req_score,
   input  logic        [POS_WIDTH-1:0]   req_region_start,
   input  logic        [POS_WIDTH-1:0]   req_region_end,
   input  logic                          req_last_interval,
   input  logic                          csr_write_enable,
   input  logic        [MODE_WIDTH-1:0]  csr_write_data,
   output logic                          rsp_has_value,
   output logic signed [VALUE_WIDTH-1:0] rsp_summary_value
);

   logic [POS_WIDTH-1:0]          istart_ff, iend_ff, rstart_ff, rend_ff;
   logic signed [VALUE_WIDTH-1:0] score_ff;
   logic                          last_ff;
   logic [MODE_WIDTH-1:0]         mode_ff;

   logic [SEEN_WIDTH-1:0]         seen_ff, seen_in;
   logic signed [VALUE_WIDTH-1:0] first_ff, first_in;
   logic signed [VALUE_WIDTH-1:0] max_ff, max_in;
   logic signed [VALUE_WIDTH-1:0] min_ff, min_in;
   logic signed [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;

   logic [POS_WIDTH-1:0]          overlap_ff, overlap_in;
   logic [COUNT_WIDTH-1:0]        weight_ff, weight_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;

   logic                          has_ff, has_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;

   logic [POS_WIDTH:0]            start_plus_one;
   logic [POS_WIDTH-1:0]          lo_pos, hi_pos;
   logic [COUNT_WIDTH-1:0]        room;
   logic [CMP_WIDTH-1:0]          overlap_ext, room_ext;
   logic signed [ACC_WIDTH-1:0]   total;
   logic [ACC_WIDTH-SUM_WIDTH:0]  total_top;
   logic signed [VALUE_WIDTH-1:0] div_quotient;
   logic                          div_done;

   iva_divider u_divider (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // Overlap of the interval with the region; a unit interval always weighs one.
   always_comb begin
      start_plus_one = {1'b0, istart_ff} + {{POS_WIDTH{1'b0}}, 1'b1};
      lo_pos = (istart_ff > rstart_ff) ? istart_ff : rstart_ff;
      hi_pos = (iend_ff < rend_ff) ? iend_ff : rend_ff;
      if (start_plus_one == {1'b0, iend_ff}) begin
         overlap_in = POS_WIDTH'(1);
      end else if (hi_pos > lo_pos) begin
         overlap_in = hi_pos - lo_pos;
      end else begin
         overlap_in = '0;
      end
   end

   // The count saturates at all ones, so the headroom is its complement.
   always_comb begin
      room        = ~count_ff;
      overlap_ext = CMP_WIDTH'(overlap_ff);
      room_ext    = CMP_WIDTH'(room);
      weight_in   = (overlap_ext > room_ext) ? room : overlap_ext[COUNT_WIDTH-1:0];
   end

   assign prod_in = score_ff * $signed({1'b0, weight_ff});

   always_comb begin
      total     = {{(ACC_WIDTH-SUM_WIDTH){sum_ff[SUM_WIDTH-1]}}, sum_ff}
                + {{(ACC_WIDTH-PROD_WIDTH){prod_ff[PROD_WIDTH-1]}}, prod_ff};
      total_top = total[ACC_WIDTH-1:SUM_WIDTH-1];
   end

   always_comb begin
      seen_in  = seen_ff;
      first_in = first_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.load_rsp) begin
         seen_in  = '0;
         first_in = '0;
         max_in   = VALUE_MIN;
         min_in   = VALUE_MAX;
         count_in = '0;
         sum_in   = '0;
      end else begin
         if (cmd.span) begin
            if (seen_ff == '0) begin
               first_in = score_ff;
            end
            if (seen_ff != SEEN_SAT) begin
               seen_in = seen_ff + SEEN_WIDTH'(1);
            end
            if (score_ff > max_ff) begin
               max_in = score_ff;
            end
            if (score_ff < min_ff) begin
               min_in = score_ff;
            end
         end
         if (cmd.clip) begin
            count_in = count_ff + weight_in;
         end
         if (cmd.acc) begin
            if ((&total_top) || !(|total_top)) begin
               sum_in = total[SUM_WIDTH-1:0];
            end else if (total[ACC_WIDTH-1]) begin
               sum_in = SUM_MIN;
            end else begin
               sum_in = SUM_MAX;
            end
         end
      end
   end

   always_comb begin
      has_in   = 1'b0;
      value_in = '0;
      if (seen_ff == SEEN_ONE) begin
         has_in   = 1'b1;
         value_in = first_ff;
      end else begin
         unique case (mode_ff)
            MODE_MAX: begin
               has_in   = 1'b1;
               value_in = max_ff;
            end
            MODE_MIN: begin
               has_in   = 1'b1;
               value_in = min_ff;
            end
            MODE_AVG: begin
               if (count_ff != '0) begin
                  has_in   = 1'b1;
                  value_in = div_quotient;
               end
            end
            MODE_NONE: begin
               has_in   = 1'b0;
            end
            default: begin
               has_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MAX;
         seen_ff  <= '0;
         first_ff <= '0;
         max_ff   <= VALUE_MIN;
         min_ff   <= VALUE_MAX;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         seen_ff  <= seen_in;
         first_ff <= first_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         istart_ff <= req_interval_start;
         iend_ff   <= req_interval_end;
         score_ff  <= req_score;
         rstart_ff <= req_region_start;
         rend_ff   <= req_region_end;
         last_ff   <= req_last_interval;
      end
      if (cmd.span) begin
         overlap_ff <= overlap_in;
      end
      if (cmd.clip) begin
         weight_ff <= weight_in;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_rsp) begin
         has_ff   <= has_in;
         value_ff <= value_in;
      end
   end

   assign status.last      = last_ff;
   assign status.needs_div = (seen_ff != SEEN_ONE) && (mode_ff == MODE_AVG) && (count_ff != '0);
   assign status.div_done  = div_done;

   assign rsp_has_value     = has_ff;
   assign rsp_summary_value = value_ff;

endmodule

// File: design/iva_controller.sv
// Controller: sequences one item through the datapath and owns both handshakes.
module iva_controller
   import iva_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SPAN   = 3'd1;
   localparam logic [2:0] ST_CLIP   = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_ACC    = 3'd4;
   localparam logic [2:0] ST_DINIT  = 3'd5;
   localparam logic [2:0] ST_DIV    = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            cmd.span = 1'b1;
            state_in = ST_CLIP;
         end
         ST_CLIP: begin
            cmd.clip = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (!status.last) begin
               req_ready = 1'b1;
               state_in  = req_valid ? ST_SPAN : ST_IDLE;
            end else if (status.needs_div) begin
               state_in = ST_DINIT;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_DINIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.capture = req_valid && req_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/interval_value_aggregator_unit.sv
// Top level of the interval value aggregator: controller plus datapath.
//
// Each req beat carries one scored interval of a group that overlaps a query
// region; the beat with req_last_interval set closes the group and produces
// exactly one rsp beat (has_value, summary_value). Other beats produce none.
// The mode register (max, min, overlap-weighted average or no value) is to be written
// by the user through csr_write_enable/csr_write_data only while the block is idle;
// the block does not enforce this. Each interval passes the overlap, clip, multiply
// and saturating accumulate steps in turn; the next beat is taken in the accumulate
// step of the previous one unless that one closes its group.
// After the closing req beat is accepted it passes the span, clip, multiply and
// accumulate steps and, when an average is divided, a divider start and the
// bit-serial divider, which retires one quotient bit per cycle, before rsp is loaded.
// Reset (synchronous, active high) sets mode to max, clears the group state
// and drops rsp_valid.
// A finished result sits in the output register; the block keeps taking the
// next group's intervals while the receiver stalls, and only waits if a new
// result is ready before the old one was taken.
module interval_value_aggregator_unit
   import iva_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic        [POS_WIDTH-1:0]   req_interval_start,
   input  logic        [POS_WIDTH-1:0]   req_interval_end,
   input  logic signed [VALUE_WIDTH-1:0] req_score,
   input  logic        [POS_WIDTH-1:0]   req_region_start,
   input  logic        [POS_WIDTH-1:0]   req_region_end,
   input  logic                          req_last_interval,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_has_value,
   output logic signed [VALUE_WIDTH-1:0] rsp_summary_value,
   input  logic                          csr_write_enable,
   input  logic        [MODE_WIDTH-1:0]  csr_write_data
);

   // Commands flow from the controller, status flows back.
   cmd_type    cmd;
   status_type status;

   iva_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   iva_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_interval_start (req_interval_start),
      .req_interval_end   (req_interval_end),
      .req_score          (req_score),
      .req_region_start   (req_region_start),
      .req_region_end     (req_region_end),
      .req_last_interval  (req_last_interval),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_has_value      (rsp_has_value),
      .rsp_summary_value  (rsp_summary_value)
   );

endmodule
